/* src/zda_pkg.sv */
// shared types and constants for the zone debounce and alarm latch
package zda_pkg;

    localparam int MAX_LANES = 8;
    localparam int ZONE_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int MODE_W    = 2;
    localparam int APB_W     = 32;
    localparam int ADDR_W    = 3;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd50;
    localparam logic [ZONE_W-1:0]  ENABLE_RESET   = 8'hFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_LOAD  = 2'd2
    } t_mode;

    typedef enum logic {
        REG_DEBOUNCE = 1'b0,
        REG_ENABLE   = 1'b1
    } t_reg_idx;

endpackage

/* src/zda_in_if.sv */
// input channel carrying one zone sample beat
interface zda_in_if;
    logic                              valid;
    logic                              ready;
    logic [zda_pkg::MODE_W-1:0]        mode;
    logic [zda_pkg::ZONE_W-1:0]        zone_sample;

    modport source (output valid, output mode, output zone_sample, input ready);
    modport sink   (input valid, input mode, input zone_sample, output ready);
endinterface

/* src/zda_out_if.sv */
// output channel carrying one debounce result beat
interface zda_out_if;
    logic                              valid;
    logic                              ready;
    logic [zda_pkg::ZONE_W-1:0]        changed_mask;
    logic [zda_pkg::ZONE_W-1:0]        stable_levels;
    logic [zda_pkg::ZONE_W-1:0]        intrusion_mask;
    logic                              alarm_latched;

    modport source (output valid, output changed_mask, output stable_levels,
                    output intrusion_mask, output alarm_latched, input ready);
    modport sink   (input valid, input changed_mask, input stable_levels,
                    input intrusion_mask, input alarm_latched, output ready);
endinterface

/* src/zone_debounce_alarm_latch.sv */
// zone debounce and alarm latch top level
//
//  channel   | dir | handshake          | payload
//  i_item    | in  | valid / ready      | mode, zone_sample
//  o_result  | out | valid / ready      | changed_mask, stable_levels, intrusion_mask,
//            |     |                    | alarm_latched
//  apb       | io  | psel / penable     | paddr, pwdata, prdata
//
// one beat per cycle while no held result is stalled, result from the result register in the cycle after acceptance
// zone state updates in the same cycle a beat is accepted, so beats follow back to back
// i_item.ready drops only while a result is held and o_result.ready is low
// synchronous active-low reset clears zone state, alarm and result valid
module zone_debounce_alarm_latch #(
    parameter int ZONES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    zda_in_if.sink                        i_item,
    zda_out_if.source                     o_result,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [zda_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [zda_pkg::APB_W-1:0]     i_pwdata,
    output logic [zda_pkg::APB_W-1:0]     o_prdata,
    output logic                          o_pready
);

    localparam int LANES = (ZONES < zda_pkg::MAX_LANES) ? ZONES : zda_pkg::MAX_LANES;

    logic [zda_pkg::COUNT_W-1:0] r_debounce_ticks;
    logic [zda_pkg::ZONE_W-1:0]  r_zone_enable;

    logic [LANES-1:0]            r_raw,    n_raw;
    logic [LANES-1:0]            r_stable, n_stable;
    logic [zda_pkg::COUNT_W-1:0] r_count [LANES];
    logic [zda_pkg::COUNT_W-1:0] n_count [LANES];
    logic                        r_alarm,  n_alarm;

    logic [LANES-1:0]            n_changed, n_intr;
    logic [LANES-1:0]            w_sample;
    logic [zda_pkg::ZONE_W-1:0]  w_changed_ext, w_stable_ext, w_intr_ext;

    logic                        r_out_valid;
    logic [zda_pkg::ZONE_W-1:0]  r_changed, r_stable_out, r_intr;
    logic                        r_alarm_out;

    logic                        w_in_accept;
    logic                        w_cfg_write;
    zda_pkg::t_reg_idx           w_reg_sel;

    // configuration port
    assign o_pready    = 1'b1;
    assign w_cfg_write = i_psel && i_penable && i_pwrite;
    assign w_reg_sel   = zda_pkg::t_reg_idx'(i_paddr[2]);

    always_comb begin
        o_prdata = '0;
        if (i_paddr[1:0] == 2'b00) begin
            case (w_reg_sel)
                zda_pkg::REG_DEBOUNCE: o_prdata[zda_pkg::COUNT_W-1:0] = r_debounce_ticks;
                zda_pkg::REG_ENABLE:   o_prdata[zda_pkg::ZONE_W-1:0]  = r_zone_enable;
                default:               o_prdata = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= zda_pkg::DEBOUNCE_RESET;
            r_zone_enable    <= zda_pkg::ENABLE_RESET;
        end else if (w_cfg_write) begin
            case (w_reg_sel)
                zda_pkg::REG_DEBOUNCE: r_debounce_ticks <= i_pwdata[zda_pkg::COUNT_W-1:0];
                zda_pkg::REG_ENABLE:   r_zone_enable    <= i_pwdata[zda_pkg::ZONE_W-1:0];
                default:               r_zone_enable    <= r_zone_enable;
            endcase
        end
    end

    // handshake
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_in_accept  = i_item.valid && i_item.ready;
    assign w_sample     = i_item.zone_sample[LANES-1:0];

    // per-zone debounce
    always_comb begin
        logic [zda_pkg::COUNT_W-1:0] v_cnt;
        n_raw     = r_raw;
        n_stable  = r_stable;
        n_count   = r_count;
        n_alarm   = r_alarm;
        n_changed = '0;
        n_intr    = '0;
        v_cnt     = '0;
        case (zda_pkg::t_mode'(i_item.mode))
            zda_pkg::MODE_TICK: begin
                for (int i = 0; i < LANES; i++) begin
                    v_cnt = (w_sample[i] != r_raw[i]) ? r_debounce_ticks : r_count[i];
                    n_raw[i]   = w_sample[i];
                    n_count[i] = v_cnt;
                    if (v_cnt != '0) begin
                        n_count[i] = v_cnt - 1'b1;
                        if (v_cnt == zda_pkg::COUNT_W'(1) && w_sample[i] != r_stable[i]) begin
                            n_stable[i]  = w_sample[i];
                            n_changed[i] = 1'b1;
                            n_intr[i]    = !w_sample[i] && r_zone_enable[i];
                        end
                    end
                end
                if (|n_intr) begin
                    n_alarm = 1'b1;
                end
            end
            zda_pkg::MODE_CLEAR: begin
                n_alarm = 1'b0;
            end
            zda_pkg::MODE_LOAD: begin
                n_raw    = w_sample;
                n_stable = w_sample;
                for (int i = 0; i < LANES; i++) begin
                    n_count[i] = '0;
                end
                n_alarm  = 1'b0;
            end
            default: begin
                n_alarm = r_alarm;
            end
        endcase
    end

    always_comb begin
        w_changed_ext              = '0;
        w_stable_ext               = '0;
        w_intr_ext                 = '0;
        w_changed_ext[LANES-1:0]   = n_changed;
        w_stable_ext[LANES-1:0]    = n_stable;
        w_intr_ext[LANES-1:0]      = n_intr;
    end

    // zone state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= '0;
            r_stable <= '0;
            r_alarm  <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                r_count[i] <= '0;
            end
        end else if (w_in_accept) begin
            r_raw    <= n_raw;
            r_stable <= n_stable;
            r_alarm  <= n_alarm;
            r_count  <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_changed    <= w_changed_ext;
            r_stable_out <= w_stable_ext;
            r_intr       <= w_intr_ext;
            r_alarm_out  <= n_alarm;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.changed_mask   = r_changed;
    assign o_result.stable_levels  = r_stable_out;
    assign o_result.intrusion_mask = r_intr;
    assign o_result.alarm_latched  = r_alarm_out;

endmodule

/* src/zda_checker.sv */
// port checker for the zone debounce and alarm latch, with its bind
module zda_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [zda_pkg::ZONE_W-1:0]   i_changed,
    input logic [zda_pkg::ZONE_W-1:0]   i_stable,
    input logic [zda_pkg::ZONE_W-1:0]   i_intr,
    input logic                         i_alarm
);

    // stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_changed)
            && $stable(i_stable) && $stable(i_intr) && $stable(i_alarm))
        else $error("stalled result beat changed");

    // nothing pending after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an intrusion is always a change
    a_intr_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_intr & ~i_changed) == '0)
        else $error("intrusion without change");

    // an intrusion zone settled low
    a_intr_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_intr & i_stable) == '0)
        else $error("intrusion on a high zone");

    // an intrusion latches the alarm
    a_intr_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_intr != '0) |-> i_alarm)
        else $error("intrusion without alarm");

endmodule

bind zone_debounce_alarm_latch zda_checker u_zda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_changed   (o_result.changed_mask),
    .i_stable    (o_result.stable_levels),
    .i_intr      (o_result.intrusion_mask),
    .i_alarm     (o_result.alarm_latched)
);

/* dv/zone_debounce_alarm_latch_tb.sv */
// self-checking testbench for the zone debounce and alarm latch
`timescale 1ns / 100ps

module zone_debounce_alarm_latch_tb;

    localparam int ZONES          = 8;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_PRINTED    = 40;

    localparam logic [zda_pkg::ZONE_W-1:0] LANE_MASK =
        (ZONES >= zda_pkg::MAX_LANES) ? {zda_pkg::ZONE_W{1'b1}} :
                                        zda_pkg::ZONE_W'((1 << ZONES) - 1);
    localparam logic [zda_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [zda_pkg::MODE_W-1:0] mode;
        logic [zda_pkg::ZONE_W-1:0] sample;
    } t_zone_beat;

    typedef struct packed {
        logic [zda_pkg::ZONE_W-1:0] changed;
        logic [zda_pkg::ZONE_W-1:0] stable;
        logic [zda_pkg::ZONE_W-1:0] intrusion;
        logic                       alarm;
    } t_zone_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_psel;
    logic                       i_penable;
    logic                       i_pwrite;
    logic [zda_pkg::ADDR_W-1:0] i_paddr;
    logic [zda_pkg::APB_W-1:0]  i_pwdata;
    logic [zda_pkg::APB_W-1:0]  o_prdata;
    logic                       o_pready;

    zda_in_if  in_if ();
    zda_out_if out_if ();

    zone_debounce_alarm_latch #(
        .ZONES (ZONES)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (in_if),
        .o_result  (out_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // predictor state and register copies
    logic [zda_pkg::COUNT_W-1:0] debounce_ticks_q;
    logic [zda_pkg::ZONE_W-1:0]  zone_enable_q;
    logic [zda_pkg::ZONE_W-1:0]  raw_last;
    logic [zda_pkg::ZONE_W-1:0]  stable_now;
    logic [zda_pkg::COUNT_W-1:0] settle_left [zda_pkg::MAX_LANES];
    logic                        alarm_now;

    t_zone_beat   pending_samples [$];
    t_zone_result expected_debounce [$];
    t_zone_beat   next_beat;
    t_zone_beat   taken_beat;
    t_zone_result seen_result;
    t_zone_result want_result;
    logic [zda_pkg::ZONE_W-1:0] last_sample;

    int send_idle;
    int recv_stall;
    int hold_reqs;
    int hold_seen;
    int hold_left;
    int errors;
    int beats_taken;
    int results_checked;
    int reg_writes;
    int quiet_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_zone_result predict_debounce(input t_zone_beat beat);
        t_zone_result               res;
        logic [zda_pkg::ZONE_W-1:0] smp;
        logic                       cur;
        smp = beat.sample & LANE_MASK;
        res = '0;
        if (beat.mode == zda_pkg::MODE_TICK) begin
            for (int i = 0; i < zda_pkg::MAX_LANES; i++) begin
                if (LANE_MASK[i]) begin
                    cur = smp[i];
                    if (cur != raw_last[i]) begin
                        settle_left[i] = debounce_ticks_q;
                        raw_last[i]    = cur;
                    end
                    if (settle_left[i] != '0) begin
                        settle_left[i] = settle_left[i] - 1'b1;
                        if (settle_left[i] == '0 && cur != stable_now[i]) begin
                            stable_now[i]  = cur;
                            res.changed[i] = 1'b1;
                            if (!cur && zone_enable_q[i]) begin
                                res.intrusion[i] = 1'b1;
                                alarm_now        = 1'b1;
                            end
                        end
                    end
                end
            end
        end else if (beat.mode == zda_pkg::MODE_CLEAR) begin
            alarm_now = 1'b0;
        end else if (beat.mode == zda_pkg::MODE_LOAD) begin
            raw_last   = smp;
            stable_now = smp;
            for (int i = 0; i < zda_pkg::MAX_LANES; i++) settle_left[i] = '0;
            alarm_now  = 1'b0;
        end
        res.stable = stable_now;
        res.alarm  = alarm_now;
        return res;
    endfunction

    task automatic report(input string msg);
        if (errors < MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                taken_beat.mode   = in_if.mode;
                taken_beat.sample = in_if.zone_sample;
                expected_debounce.push_back(predict_debounce(taken_beat));
                beats_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle) begin
                    next_beat         = pending_samples.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.mode        <= next_beat.mode;
                    in_if.zone_sample <= next_beat.sample;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result sink, with the long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen    <= hold_reqs;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen_result.changed   = out_if.changed_mask;
            seen_result.stable    = out_if.stable_levels;
            seen_result.intrusion = out_if.intrusion_mask;
            seen_result.alarm     = out_if.alarm_latched;
            if (expected_debounce.size() == 0) begin
                report($sformatf("result beat with nothing expected: %h", seen_result));
            end else begin
                want_result = expected_debounce.pop_front();
                if (seen_result.changed !== want_result.changed)
                    report($sformatf("changed_mask got %h want %h",
                                     seen_result.changed, want_result.changed));
                if (seen_result.stable !== want_result.stable)
                    report($sformatf("stable_levels got %h want %h",
                                     seen_result.stable, want_result.stable));
                if (seen_result.intrusion !== want_result.intrusion)
                    report($sformatf("intrusion_mask got %h want %h",
                                     seen_result.intrusion, want_result.intrusion));
                if (seen_result.alarm !== want_result.alarm)
                    report($sformatf("alarm_latched got %b want %b",
                                     seen_result.alarm, want_result.alarm));
                results_checked++;
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (i_psel && i_penable && o_pready) || !i_rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL zone_debounce_alarm_latch");
        $finish;
    end

    task automatic queue_beat(input logic [zda_pkg::MODE_W-1:0] mode,
                              input logic [zda_pkg::ZONE_W-1:0] smp);
        t_zone_beat beat;
        beat.mode   = mode;
        beat.sample = smp;
        pending_samples.push_back(beat);
    endtask

    task automatic queue_hold(input logic [zda_pkg::ZONE_W-1:0] smp, input int n);
        repeat (n) queue_beat(zda_pkg::MODE_TICK, smp);
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || in_if.valid || expected_debounce.size() != 0)
            @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_register(input zda_pkg::t_reg_idx idx, input logic [7:0] value);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= {{(zda_pkg::APB_W-8){1'b0}}, value};
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        if (idx == zda_pkg::REG_DEBOUNCE) debounce_ticks_q = value;
        else zone_enable_q = value;
        reg_writes++;
    endtask

    task automatic set_phase(input logic [7:0] ticks, input logic [7:0] enables,
                             input int idle_pct, input int stall_pct);
        drain();
        write_register(zda_pkg::REG_DEBOUNCE, ticks);
        write_register(zda_pkg::REG_ENABLE, enables);
        send_idle  = idle_pct;
        recv_stall = stall_pct;
    endtask

    // mostly held levels long enough to settle, some glitches, some mode noise
    task automatic queue_random(input int n);
        int                         left;
        int                         len;
        int                         pick;
        int                         settle;
        logic [zda_pkg::ZONE_W-1:0] smp;
        smp    = last_sample;
        left   = n;
        settle = (debounce_ticks_q == 0) ? 1 : int'(debounce_ticks_q);
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                queue_beat(zda_pkg::MODE_CLEAR, zda_pkg::ZONE_W'($urandom));
                left--;
            end else if (pick < 9) begin
                smp = zda_pkg::ZONE_W'($urandom);
                queue_beat(zda_pkg::MODE_LOAD, smp);
                left--;
            end else if (pick < 11) begin
                queue_beat(MODE_UNUSED, zda_pkg::ZONE_W'($urandom));
                left--;
            end else begin
                smp = smp ^ (zda_pkg::ZONE_W'($urandom & $urandom) |
                             (zda_pkg::ZONE_W'(1) << $urandom_range(zda_pkg::ZONE_W-1)));
                if ($urandom_range(3) == 0 && settle > 1)
                    len = $urandom_range(settle - 1, 1);
                else
                    len = settle + $urandom_range(3);
                queue_hold(smp, len);
                left -= len;
            end
        end
        last_sample = smp;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_psel            = 1'b0;
        i_penable         = 1'b0;
        i_pwrite          = 1'b0;
        i_paddr           = '0;
        i_pwdata          = '0;
        in_if.valid       = 1'b0;
        in_if.mode        = zda_pkg::MODE_TICK;
        in_if.zone_sample = '0;
        out_if.ready      = 1'b0;
        debounce_ticks_q  = zda_pkg::DEBOUNCE_RESET;
        zone_enable_q     = zda_pkg::ENABLE_RESET;
        raw_last          = '0;
        stable_now        = '0;
        for (int i = 0; i < zda_pkg::MAX_LANES; i++) settle_left[i] = '0;
        alarm_now         = 1'b0;
        last_sample       = '0;
        send_idle         = 0;
        recv_stall        = 0;
        hold_reqs         = 0;
        hold_seen         = 0;
        errors            = 0;
        beats_taken       = 0;
        results_checked   = 0;
        reg_writes        = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register values from reset
        queue_beat(MODE_UNUSED, 8'hAA);
        queue_beat(zda_pkg::MODE_CLEAR, 8'hFF);
        queue_beat(zda_pkg::MODE_LOAD, 8'hFF);
        queue_beat(zda_pkg::MODE_TICK, 8'h00);
        queue_beat(zda_pkg::MODE_TICK, 8'hFF);

        // shortest debounce, partial enable mask
        set_phase(8'd1, 8'hA5, 0, 0);
        queue_beat(zda_pkg::MODE_TICK, 8'h00);
        queue_beat(MODE_UNUSED, 8'h00);
        queue_beat(zda_pkg::MODE_CLEAR, 8'h55);
        queue_beat(zda_pkg::MODE_TICK, 8'hFF);
        queue_beat(zda_pkg::MODE_LOAD, 8'h0F);
        queue_beat(zda_pkg::MODE_TICK, 8'h0F);

        // zero debounce tracks the raw level but never settles the change, even after a later nonzero reload
        set_phase(8'd0, 8'hFF, 0, 0);
        queue_hold(8'hF0, 2);
        set_phase(8'd2, 8'hFF, 0, 0);
        queue_hold(8'hF0, 2);
        queue_hold(8'h00, 2);
        queue_beat(zda_pkg::MODE_TICK, 8'h80);
        queue_hold(8'h00, 3);
        last_sample = 8'h00;

        set_phase(8'($urandom_range(3, 1)), 8'hFF, 0, 0);
        queue_random(25);
        set_phase(8'd1, 8'h00, 58, 0);
        queue_random(25);
        set_phase(8'd4, 8'($urandom), 0, 58);
        queue_random(25);
        set_phase(8'($urandom_range(6, 1)), 8'($urandom), 28, 28);
        queue_random(25);

        // sink backs off while the source keeps offering
        set_phase(8'd2, 8'($urandom), 0, 0);
        queue_random(25);
        @(posedge i_clk);
        hold_reqs <= hold_reqs + 1;

        // longest debounce, with one glitch on zone 0 partway through
        set_phase(8'd255, 8'hFF, 28, 28);
        queue_beat(zda_pkg::MODE_LOAD, 8'hFF);
        queue_hold(8'h00, 200);
        queue_beat(zda_pkg::MODE_TICK, 8'h01);
        queue_hold(8'h00, 60);

        drain();
        repeat (4) @(posedge i_clk);
        if (expected_debounce.size() != 0)
            report($sformatf("%0d results never arrived", expected_debounce.size()));

        $display("checked %0d results from %0d sample beats over %0d register writes",
                 results_checked, beats_taken, reg_writes);
        $display("debounce 0 to 255, enable masks 00 a5 ff and random, idle and stall mixes");
        if (errors == 0) begin
            $display("PASS zone_debounce_alarm_latch");
        end else begin
            $display("FAIL zone_debounce_alarm_latch");
        end
        $finish;
    end

endmodule
